[hw/rtl/rdc_pkg.sv]
// Package for the radix digit converter: shared types, constants and the
// digit to ASCII mapping. Depends on nothing.
package rdc_pkg;

  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } rdc_state_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d <= DIGIT_NINE) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

[hw/rtl/rdc_cell.sv]
// One digit cell of the conversion chain: doubles its digit and adds the
// incoming carry modulo the radix, or shifts digits up during output.
// Depends on rdc_pkg.
module rdc_cell
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [RADIX_W-1:0] radix,
  input  logic               act_in,
  input  logic               carry_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               act,
  output logic               carry,
  output logic [DIGIT_W-1:0] digit
);

  logic [RADIX_W-1:0] sum;
  logic               wrap;
  logic [RADIX_W-1:0] diff;

  assign sum  = {digit, carry_in};
  assign wrap = (sum >= radix);
  assign diff = sum - radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      act   <= 1'b0;
      carry <= 1'b0;
    end else begin
      act   <= act_in & ~ctrl.clr;
      carry <= act_in & wrap & ~ctrl.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end else if (act_in) begin
      digit <= wrap ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
    end
  end

endmodule

[hw/rtl/rdc_ctrl.sv]
// Sequencer of the radix digit converter: feeds the value into the cell
// chain one bit at a time, then reads digits out of the top cell.
// Depends on rdc_pkg.
module rdc_ctrl
  import rdc_pkg::*;
#(
  parameter int VALUE_WIDTH = 31,
  parameter int MAX_DIGITS  = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_W-1:0]     radix,
  output cell_ctrl_t             cctl,
  output logic [RADIX_W-1:0]     radix_sat,
  output logic                   act0,
  output logic                   bit0,
  input  logic [DIGIT_W-1:0]     top_digit,
  input  logic                   top_carry,
  output logic                   digit_valid,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last
);

  localparam int CNT_W  = $clog2(VALUE_WIDTH + MAX_DIGITS);
  localparam int ECNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0]  CONV_LAST = CNT_W'(VALUE_WIDTH + MAX_DIGITS - 2);
  localparam logic [CNT_W-1:0]  FEED_CYC  = CNT_W'(VALUE_WIDTH);
  localparam logic [ECNT_W-1:0] EMIT_CYC  = ECNT_W'(MAX_DIGITS);
  localparam logic [ECNT_W-1:0] ECNT_ONE  = ECNT_W'(1);

  rdc_state_t             state, state_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [ECNT_W-1:0]      ecnt, ecnt_next;
  logic                   ovf, ovf_next;
  logic                   started, started_next;
  logic [VALUE_WIDTH-1:0] sr, sr_next;
  logic                   ovf_eff;
  logic                   emit_now;
  logic                   accept;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign bit0       = sr[VALUE_WIDTH-1];
  assign ovf_eff    = ovf | top_carry;
  assign emit_now   = started || (top_digit != '0) || ovf_eff || (ecnt == ECNT_ONE);
  assign digit_char = digit_to_ascii(top_digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      ecnt    <= '0;
      ovf     <= 1'b0;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      ecnt    <= ecnt_next;
      ovf     <= ovf_next;
      started <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    sr <= sr_next;
    if (accept) begin
      if (radix < RADIX_MIN) begin
        radix_sat <= RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
        radix_sat <= RADIX_MAX;
      end else begin
        radix_sat <= radix;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ecnt_next    = ecnt;
    ovf_next     = ovf;
    started_next = started;
    sr_next      = sr;
    act0         = 1'b0;
    cctl         = '{clr: 1'b0, shift: 1'b0};
    digit_valid  = 1'b0;
    last         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cctl.clr     = 1'b1;
          sr_next      = value;
          cnt_next     = '0;
          ovf_next     = 1'b0;
          started_next = 1'b0;
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        act0     = (cnt < FEED_CYC);
        sr_next  = {sr[VALUE_WIDTH-2:0], 1'b0};
        ovf_next = ovf_eff;
        if (cnt == CONV_LAST) begin
          ecnt_next  = EMIT_CYC;
          state_next = S_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMIT: begin
        cctl.shift   = 1'b1;
        ovf_next     = ovf_eff;
        digit_valid  = emit_now;
        last         = (ecnt == ECNT_ONE);
        started_next = emit_now;
        if (ecnt == ECNT_ONE) begin
          state_next = S_IDLE;
        end else begin
          ecnt_next = ecnt - 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> busy)
    else $error("digit strobe outside a conversion");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last |-> digit_valid)
    else $error("last mark without a digit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !digit_valid)
    else $error("accepted transfer did not start a conversion");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && last) |=> !busy)
    else $error("still busy after the final digit");

endmodule

[hw/rtl/radix_digit_converter_top.sv]
// Radix digit converter: a value is shifted one bit per cycle, most
// significant first, through a chain of MAX_DIGITS digit cells; the digits
// are then shifted out of the top cell. Each digit transfer is marked by
// digit_valid for one cycle and cannot be held off by the receiver. An item
// occupies the block from the accepting edge until start can be taken
// again: its bits are fed into the chain, carries ripple to the top cell,
// digits are shifted out of the top cell with leading zeros being dropped
// silently, and the block passes through its idle state before the next
// transfer. Depends on rdc_pkg, rdc_cell and rdc_ctrl.
module radix_digit_converter_top
  import rdc_pkg::*;
#(
  parameter int VALUE_WIDTH = 31,
  parameter int MAX_DIGITS  = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_W-1:0]     radix,
  output logic                   digit_valid,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last
);

  cell_ctrl_t         cctl;
  logic [RADIX_W-1:0] radix_sat;
  logic               act0;
  logic               bit0;
  logic               act   [MAX_DIGITS];
  logic               carry [MAX_DIGITS];
  logic [DIGIT_W-1:0] digit [MAX_DIGITS];

  rdc_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .radix      (radix),
    .cctl       (cctl),
    .radix_sat  (radix_sat),
    .act0       (act0),
    .bit0       (bit0),
    .top_digit  (digit[MAX_DIGITS-1]),
    .top_carry  (carry[MAX_DIGITS-1]),
    .digit_valid(digit_valid),
    .digit_char (digit_char),
    .last       (last)
  );

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    if (k == 0) begin : g_first
      rdc_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (cctl),
        .radix   (radix_sat),
        .act_in  (act0),
        .carry_in(bit0),
        .digit_in('0),
        .act     (act[k]),
        .carry   (carry[k]),
        .digit   (digit[k])
      );
    end else begin : g_next
      rdc_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (cctl),
        .radix   (radix_sat),
        .act_in  (act[k-1]),
        .carry_in(carry[k-1]),
        .digit_in(digit[k-1]),
        .act     (act[k]),
        .carry   (carry[k]),
        .digit   (digit[k])
      );
    end
  end

endmodule

[verif/radix_digit_converter_top_tb.sv]
// Testbench for radix_digit_converter_top: sends numbers with a radix and checks
// every emitted ASCII digit against a built-in model of the conversion.
// Depends on rdc_pkg and the radix_digit_converter_top RTL.
`timescale 1ns / 1ps

module radix_digit_converter_top_tb;
  import rdc_pkg::*;

  localparam int VALUE_WIDTH = 31;
  localparam int MAX_DIGITS  = 31;
  localparam int ITEM_CYCLES = VALUE_WIDTH + 2 * MAX_DIGITS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [VALUE_WIDTH-1:0] value;
  logic [RADIX_W-1:0]     radix;
  logic                   digit_valid;
  logic [CHAR_W-1:0]      digit_char;
  logic                   last;

  digit_t expected_digits[$];
  int     error_count;
  int     cycle_count;

  radix_digit_converter_top #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .radix      (radix),
    .digit_valid(digit_valid),
    .digit_char (digit_char),
    .last       (last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    if (d < 4'd10) begin
      return 7'd48 + CHAR_W'(d);
    end
    return 7'd65 + CHAR_W'(d - 4'd10);
  endfunction

  // Expected digits of one number, most significant first.
  function automatic void queue_digits(input logic [VALUE_WIDTH-1:0] num,
                                       input logic [RADIX_W-1:0] base_in);
    logic [RADIX_W-1:0]     base;
    logic [VALUE_WIDTH-1:0] rest;
    logic [DIGIT_W-1:0]     digs[MAX_DIGITS];
    int                     n;
    digit_t                 d;
    if (base_in < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base_in > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = base_in;
    end
    rest = num;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      d.ch = ascii_of(digs[k]);
      d.last = (k == 0);
      expected_digits.push_back(d);
    end
  endfunction

  // Start stays high across back-to-back items; it is only lowered in gaps.
  task automatic send_number(input logic [VALUE_WIDTH-1:0] num,
                             input logic [RADIX_W-1:0] base, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    value <= num;
    radix <= base;
    do @(posedge clk); while (busy);
    queue_digits(num, base);
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    int n;
    n = $urandom_range(1, VALUE_WIDTH);
    return VALUE_WIDTH'($urandom) & VALUE_WIDTH'((64'd1 << n) - 1);
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    if ($urandom_range(9) == 0) begin
      return RADIX_W'($urandom_range(0, 31));
    end
    return RADIX_W'($urandom_range(2, 16));
  endfunction

  task automatic test_reset();
    rst <= 1'b1;
    start <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_values();
    localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;
    send_number('0, 5'd2, 0);
    send_number('0, 5'd10, 0);
    send_number('0, 5'd16, 0);
    send_number(31'd1, 5'd2, 0);
    send_number(ALL_ONES, 5'd2, 0);
    send_number(ALL_ONES, 5'd3, 0);
    send_number(ALL_ONES, 5'd10, 0);
    send_number(ALL_ONES, 5'd16, 0);
    send_number(31'h5555_5555, 5'd2, 0);
    send_number(31'h2AAA_AAAA, 5'd2, 0);
    send_number(31'd15, 5'd16, 0);
    send_number(31'd16, 5'd16, 0);
    send_number(31'd10, 5'd11, 0);
    send_number(31'd9, 5'd10, 0);
    send_number(31'd224, 5'd15, 0);
    send_number(31'd1000000000, 5'd10, 0);
    send_number(31'd12345, 5'd7, 0);
    // Radix values outside 2..16 saturate to the nearest legal base.
    send_number(31'd77, 5'd0, 0);
    send_number(31'd77, 5'd1, 0);
    send_number(31'd255, 5'd17, 0);
    send_number(31'h7ABC_DEF0, 5'd31, 0);
    send_number(ALL_ONES, 5'd31, 0);
    pause_until_drained();
  endtask

  task automatic test_random_numbers(input int count, input int idle_pct,
                                     input bit drain_midway);
    for (int i = 0; i < count; i++) begin
      if (drain_midway && i == count / 2) begin
        pause_until_drained();
      end
      send_number(random_value(), random_radix(), idle_pct);
    end
  endtask

  // Each digit transfer lasts one cycle and is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && digit_valid) begin
      if (expected_digits.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
          $display("Unexpected digit: char %0d last %0d", digit_char, last);
        end
      end else begin
        if (digit_char !== expected_digits[0].ch || last !== expected_digits[0].last) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("Digit mismatch: expected char %0d last %0d, got char %0d last %0d",
                     expected_digits[0].ch, expected_digits[0].last, digit_char, last);
          end
        end
        void'(expected_digits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    radix = '0;
    error_count = 0;
    cycle_count = 0;
    test_reset();
    test_directed_values();
    test_random_numbers(34, 17, 1'b1);
    test_random_numbers(33, 78, 1'b0);
    test_random_numbers(33, 0, 1'b0);
    start <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[radix_digit_converter_top.f]
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_cell.sv
hw/rtl/rdc_ctrl.sv
hw/rtl/radix_digit_converter_top.sv
verif/radix_digit_converter_top_tb.sv
